/* rtl/efss_pkg.sv */
// Shared types and constants for the earliest-free server scheduler.
// Depends on nothing; imported by every module of the block.
package efss_pkg;

    // Server pool
    localparam int MAX_WINDOWS = 16;
    localparam int WIN_W       = $clog2(MAX_WINDOWS);
    localparam int SRV_W       = $clog2(MAX_WINDOWS + 1);

    // Field widths
    localparam int ARR_W  = 17;
    localparam int MIN_W  = 8;
    localparam int TIME_W = 24;
    localparam int SUM_W  = 40;
    localparam int CNT_W  = 24;
    localparam int SVC_W  = 14;
    localparam int NW_W   = 5;
    localparam int CFG_W  = 17;
    localparam int CIDX_W = 2;

    localparam int SEC_PER_MIN = 60;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_NUM_WINDOWS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_OPEN_TIME   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CLOSE_TIME  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_SERVICE = 2'd3;

    // Register reset values
    localparam logic [NW_W-1:0]  NUM_WINDOWS_RST = 5'd1;
    localparam logic [ARR_W-1:0] OPEN_TIME_RST   = 17'd28800;
    localparam logic [ARR_W-1:0] CLOSE_TIME_RST  = 17'd61200;
    localparam logic [MIN_W-1:0] MAX_SERVICE_RST = 8'd60;

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [NW_W-1:0]  num_windows;
        logic [ARR_W-1:0] open_time;
        logic [ARR_W-1:0] close_time;
        logic [MIN_W-1:0] max_service_minutes;
    } cfg_t;

    typedef struct packed {
        logic             accepted;
        logic [ARR_W-1:0] arrival;
        logic [SVC_W-1:0] service;
    } job_t;

endpackage

/* rtl/efss_front.sv */
// Front end: takes job beats, checks them against closing time, caps and scales service.
// Depends on efss_pkg.
module efss_front (
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [efss_pkg::ARR_W-1:0] s_arrival_seconds,
    input  logic [efss_pkg::MIN_W-1:0] s_service_minutes,
    input  efss_pkg::cfg_t            cfg,
    input  logic                      q_full,
    output logic                      q_push,
    output efss_pkg::job_t            q_data
);
    import efss_pkg::*;

    logic [MIN_W-1:0] min_cap;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Cap minutes, then scale to seconds
    assign min_cap = (s_service_minutes > cfg.max_service_minutes) ?
                     cfg.max_service_minutes : s_service_minutes;

    always_comb begin
        q_data.accepted = (s_arrival_seconds <= cfg.close_time);
        q_data.arrival  = s_arrival_seconds;
        q_data.service  = SVC_W'(min_cap) * SVC_W'(SEC_PER_MIN);
    end

endmodule

/* rtl/efss_queue.sv */
// Two-entry job queue decoupling the front end from the scheduler core.
// Depends on efss_pkg.
module efss_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  efss_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output efss_pkg::job_t pop_data,
    output logic           not_empty
);
    import efss_pkg::*;

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/efss_back.sv */
// Scheduler core: scans server free times, assigns the job, keeps totals, holds the result.
// Depends on efss_pkg.
module efss_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  efss_pkg::cfg_t             cfg,
    input  logic                       load_free,
    input  logic [efss_pkg::ARR_W-1:0] load_value,
    input  logic                       q_not_empty,
    input  efss_pkg::job_t             q_data,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic [efss_pkg::WIN_W-1:0]  m_window_index,
    output logic [efss_pkg::TIME_W-1:0] m_wait_seconds,
    output logic [efss_pkg::SUM_W-1:0]  m_total_wait,
    output logic [efss_pkg::CNT_W-1:0]  m_customer_count
);
    import efss_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]        state_reg,  state_next;
    job_t              job_reg,    job_next;
    logic [SRV_W-1:0]  scan_reg,   scan_next;
    logic [WIN_W-1:0]  best_reg,   best_next;
    logic [TIME_W-1:0] best_t_reg, best_t_next;
    logic [TIME_W-1:0] wait_reg,   wait_next;
    logic [SUM_W-1:0]  sum_reg,    sum_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [TIME_W-1:0] free_reg [MAX_WINDOWS];

    logic              out_valid_reg;
    logic              out_acc_reg;
    logic [WIN_W-1:0]  out_win_reg;
    logic [TIME_W-1:0] out_wait_reg;
    logic [SUM_W-1:0]  out_sum_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    logic [SRV_W-1:0]  servers;
    logic [TIME_W-1:0] scan_t;
    logic [TIME_W-1:0] arr_ext;
    logic              late_free;
    logic [TIME_W:0]   end_sum;
    logic [TIME_W-1:0] end_sat;
    logic [SUM_W:0]    sum_add;
    logic              out_load;

    // Effective server count, clamped to 1..MAX_WINDOWS
    always_comb begin
        if (cfg.num_windows == '0) begin
            servers = SRV_W'(1);
        end else if (SRV_W'(cfg.num_windows) > SRV_W'(MAX_WINDOWS)) begin
            servers = SRV_W'(MAX_WINDOWS);
        end else begin
            servers = SRV_W'(cfg.num_windows);
        end
    end

    assign scan_t    = free_reg[scan_reg[WIN_W-1:0]];
    assign arr_ext   = TIME_W'(job_reg.arrival);
    assign late_free = (best_t_reg > arr_ext);
    assign end_sum   = (late_free ? {1'b0, best_t_reg} : {1'b0, arr_ext})
                     + (TIME_W + 1)'(job_reg.service);
    assign end_sat   = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
    assign sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(wait_reg);
    assign out_load  = (state_reg == ST_RESULT) && (!out_valid_reg || m_ready);
    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        job_next    = job_reg;
        scan_next   = scan_reg;
        best_next   = best_reg;
        best_t_next = best_t_reg;
        wait_next   = wait_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    job_next    = q_data;
                    best_next   = '0;
                    best_t_next = free_reg[0];
                    scan_next   = SRV_W'(1);
                    wait_next   = '0;
                    state_next  = q_data.accepted ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (scan_reg < servers) begin
                    if (scan_t < best_t_reg) begin
                        best_next   = scan_reg[WIN_W-1:0];
                        best_t_next = scan_t;
                    end
                    scan_next = scan_reg + 1'b1;
                end else begin
                    wait_next  = late_free ? (best_t_reg - arr_ext) : '0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                cnt_next   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        scan_reg   <= scan_next;
        best_reg   <= best_next;
        best_t_reg <= best_t_next;
        wait_reg   <= wait_next;
    end

    // Server free times: reload on opening time, update the chosen server
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_WINDOWS; i++) free_reg[i] <= TIME_W'(OPEN_TIME_RST);
        end else if (load_free) begin
            for (int i = 0; i < MAX_WINDOWS; i++) free_reg[i] <= TIME_W'(load_value);
        end else if (state_reg == ST_UPDATE) begin
            free_reg[best_reg] <= end_sat;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_acc_reg  <= job_reg.accepted;
            out_win_reg  <= job_reg.accepted ? best_reg : '0;
            out_wait_reg <= wait_reg;
            out_sum_reg  <= sum_reg;
            out_cnt_reg  <= cnt_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_accepted       = out_acc_reg;
    assign m_window_index   = out_win_reg;
    assign m_wait_seconds   = out_wait_reg;
    assign m_total_wait     = out_sum_reg;
    assign m_customer_count = out_cnt_reg;

endmodule

/* rtl/earliest_free_server_scheduler.sv */
// Top level of the earliest-free server scheduler: config registers, front end, queue, core.
// Depends on efss_pkg, efss_front, efss_queue and efss_back.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    arrival_seconds, service_minutes
//  m_        out        m_valid/m_ready    accepted, window_index, wait_seconds,
//                                          total_wait, customer_count
//  cfg_      in         cfg_we (no wait)   cfg_index, cfg_wdata
//
// In the core an accepted job goes through the load, free-time scan (over the servers in
// use), update and result states; a job past closing time goes from load straight to
// result. The result state waits until the result register can take the result.
// Reset is synchronous; free times come out of reset at the opening time at once.
// The two-entry queue keeps taking beats while a result waits on m_ready, until it is full.
module earliest_free_server_scheduler (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [efss_pkg::ARR_W-1:0]  s_arrival_seconds,
    input  logic [efss_pkg::MIN_W-1:0]  s_service_minutes,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_accepted,
    output logic [efss_pkg::WIN_W-1:0]  m_window_index,
    output logic [efss_pkg::TIME_W-1:0] m_wait_seconds,
    output logic [efss_pkg::SUM_W-1:0]  m_total_wait,
    output logic [efss_pkg::CNT_W-1:0]  m_customer_count,
    input  logic                        cfg_we,
    input  logic [efss_pkg::CIDX_W-1:0] cfg_index,
    input  logic [efss_pkg::CFG_W-1:0]  cfg_wdata
);
    import efss_pkg::*;

    cfg_t cfg_reg;
    job_t push_data;
    job_t pop_data;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    logic load_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_windows         <= NUM_WINDOWS_RST;
            cfg_reg.open_time           <= OPEN_TIME_RST;
            cfg_reg.close_time          <= CLOSE_TIME_RST;
            cfg_reg.max_service_minutes <= MAX_SERVICE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_NUM_WINDOWS: cfg_reg.num_windows         <= cfg_wdata[NW_W-1:0];
                CFG_OPEN_TIME:   cfg_reg.open_time           <= cfg_wdata[ARR_W-1:0];
                CFG_CLOSE_TIME:  cfg_reg.close_time          <= cfg_wdata[ARR_W-1:0];
                CFG_MAX_SERVICE: cfg_reg.max_service_minutes <= cfg_wdata[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Opening time write reloads every server free time
    assign load_free = cfg_we && (cfg_index == CFG_OPEN_TIME);

    efss_front u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_arrival_seconds (s_arrival_seconds),
        .s_service_minutes (s_service_minutes),
        .cfg               (cfg_reg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_data            (push_data)
    );

    efss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty)
    );

    efss_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .load_free        (load_free),
        .load_value       (cfg_wdata[ARR_W-1:0]),
        .q_not_empty      (q_not_empty),
        .q_data           (pop_data),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_window_index   (m_window_index),
        .m_wait_seconds   (m_wait_seconds),
        .m_total_wait     (m_total_wait),
        .m_customer_count (m_customer_count)
    );

endmodule

/* rtl/efss_checker.sv */
// Port-level checks for the earliest-free server scheduler, bound to the top level.
// Depends on efss_pkg and earliest_free_server_scheduler.
module efss_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_accepted,
    input logic [efss_pkg::WIN_W-1:0]  m_window_index,
    input logic [efss_pkg::TIME_W-1:0] m_wait_seconds,
    input logic [efss_pkg::SUM_W-1:0]  m_total_wait,
    input logic [efss_pkg::CNT_W-1:0]  m_customer_count
);
    import efss_pkg::*;

    // No result beat right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result beat holds its valid, wait, total and count
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_wait)
            && $stable(m_customer_count) && $stable(m_wait_seconds))
        else $error("stalled result beat changed");

    // A rejected job carries no server and no wait
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> m_window_index == '0 && m_wait_seconds == '0)
        else $error("rejected job with server or wait");

    // An accepted job has been counted
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_customer_count != '0)
        else $error("accepted job with zero count");

endmodule

bind earliest_free_server_scheduler efss_checker u_efss_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_accepted       (m_accepted),
    .m_window_index   (m_window_index),
    .m_wait_seconds   (m_wait_seconds),
    .m_total_wait     (m_total_wait),
    .m_customer_count (m_customer_count)
);
